/* design/expression_tokenizer_core_macros.svh */
// Assertion macros used by the tokenizer top level.
// Define ASSERT_OFF to compile the checks out.
`ifndef EXPRESSION_TOKENIZER_CORE_MACROS_SVH
`define EXPRESSION_TOKENIZER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Check that holds outside reset.
`define ETOK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also holds while reset is applied.
`define ETOK_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ETOK_ASSERT(lbl, prop, msg)
`define ETOK_ASSERT_RST(lbl, prop, msg)

`endif

`endif

/* design/etok_pkg.sv */
package etok_pkg;

  // Width of the internal wrapping byte offset counter.
  localparam int OFFSET_BITS = 16;
  // Width of the start and length fields of a token.
  localparam int TOK_BITS = 16;
  // Most tokens a single input transfer can produce.
  localparam int MAX_TOK = 4;
  localparam int TOK_IDX_BITS = $clog2(MAX_TOK);
  localparam int TOK_CNT_BITS = $clog2(MAX_TOK + 1);
  // Bundles held between scanner and output stage.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

  typedef logic [OFFSET_BITS-1:0] off_t;
  typedef logic [TOK_BITS-1:0] tok_field_t;

  typedef enum logic [3:0] {
    K_NUMBER    = 4'd0,
    K_IDENT     = 4'd1,
    K_PLUS      = 4'd2,
    K_MINUS     = 4'd3,
    K_STAR      = 4'd4,
    K_BANG      = 4'd5,
    K_SLASH     = 4'd6,
    K_CARET     = 4'd7,
    K_LPAREN    = 4'd8,
    K_RPAREN    = 4'd9,
    K_COMMA     = 4'd10,
    K_SEMICOLON = 4'd11,
    K_LBRACKET  = 4'd12,
    K_RBRACKET  = 4'd13,
    K_EOF       = 4'd14,
    K_ERROR     = 4'd15
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    tok_field_t start;
    tok_field_t len;
  } tok_t;

  // All tokens caused by one input transfer.
  typedef struct packed {
    logic [TOK_CNT_BITS-1:0] cnt;
    tok_t [MAX_TOK-1:0]      tok;
  } bundle_t;

  // Queue status seen by the scanner and the output stage.
  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

endpackage

/* design/etok_front.sv */
module etok_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [7:0]           in_char_byte,
  input  logic                 in_end_of_source,
  output logic                 in_ready,
  input  etok_pkg::q_stat_t    q_stat,
  output logic                 push,
  output etok_pkg::bundle_t    push_data
);

  typedef enum logic [2:0] {
    M_IDLE     = 3'd0,
    M_IDENT    = 3'd1,
    M_INT      = 3'd2,
    M_DOT      = 3'd3,
    M_FRAC     = 3'd4,
    M_EXP_E    = 3'd5,
    M_EXP_SIGN = 3'd6,
    M_EXP_DIG  = 3'd7
  } mode_t;

  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_STAR  = "*";
  localparam logic [7:0] CH_BANG  = "!";
  localparam logic [7:0] CH_SLASH = "/";
  localparam logic [7:0] CH_CARET = "^";
  localparam logic [7:0] CH_LPAR  = "(";
  localparam logic [7:0] CH_RPAR  = ")";
  localparam logic [7:0] CH_COMMA = ",";
  localparam logic [7:0] CH_SEMI  = ";";
  localparam logic [7:0] CH_LBRK  = "[";
  localparam logic [7:0] CH_RBRK  = "]";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_UNDER = "_";
  localparam logic [7:0] CH_LO_E  = "e";
  localparam logic [7:0] CH_UP_E  = "E";
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam etok_pkg::off_t OFF_ONE = etok_pkg::off_t'(1);
  localparam etok_pkg::tok_field_t LEN_ONE = etok_pkg::tok_field_t'(1);
  localparam etok_pkg::tok_field_t LEN_TWO = etok_pkg::tok_field_t'(2);

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic etok_pkg::tok_field_t sat_inc(input etok_pkg::tok_field_t v);
    return (v == '1) ? v : v + LEN_ONE;
  endfunction

  function automatic etok_pkg::kind_t op_kind(input logic [7:0] c);
    etok_pkg::kind_t k;
    unique case (c)
      CH_PLUS:  k = etok_pkg::K_PLUS;
      CH_MINUS: k = etok_pkg::K_MINUS;
      CH_STAR:  k = etok_pkg::K_STAR;
      CH_BANG:  k = etok_pkg::K_BANG;
      CH_SLASH: k = etok_pkg::K_SLASH;
      CH_CARET: k = etok_pkg::K_CARET;
      CH_LPAR:  k = etok_pkg::K_LPAREN;
      CH_RPAR:  k = etok_pkg::K_RPAREN;
      CH_COMMA: k = etok_pkg::K_COMMA;
      CH_SEMI:  k = etok_pkg::K_SEMICOLON;
      CH_LBRK:  k = etok_pkg::K_LBRACKET;
      CH_RBRK:  k = etok_pkg::K_RBRACKET;
      default:  k = etok_pkg::K_ERROR;
    endcase
    return k;
  endfunction

  function automatic etok_pkg::tok_t mk_tok(input etok_pkg::kind_t k,
                                            input etok_pkg::off_t start,
                                            input etok_pkg::tok_field_t len);
    etok_pkg::tok_t t;
    t.kind  = k;
    t.start = etok_pkg::tok_field_t'(start);
    t.len   = len;
    return t;
  endfunction

  mode_t                mode_r, mode_nxt;
  etok_pkg::off_t       offset_r, offset_nxt;
  etok_pkg::off_t       begin_r, begin_nxt;
  etok_pkg::off_t       mark_r, mark_nxt;
  logic                 sign_minus_r, sign_minus_nxt;
  etok_pkg::tok_field_t run_len_r, run_len_nxt;
  etok_pkg::tok_field_t mant_len_r, mant_len_nxt;

  etok_pkg::tok_t [etok_pkg::MAX_TOK-1:0] toks;
  logic [etok_pkg::TOK_CNT_BITS-1:0]      n;
  logic                                   brk;
  logic                                   acc;
  logic [7:0]                             c;
  logic                                   is_e;

  assign c        = in_char_byte;
  assign is_e     = (c == CH_LO_E) || (c == CH_UP_E);
  assign in_ready = !q_stat.full;
  assign acc      = in_valid && in_ready;

  always_comb begin
    mode_nxt       = mode_r;
    begin_nxt      = begin_r;
    mark_nxt       = mark_r;
    sign_minus_nxt = sign_minus_r;
    run_len_nxt    = run_len_r;
    mant_len_nxt   = mant_len_r;
    offset_nxt     = in_end_of_source ? offset_r : offset_r + OFF_ONE;
    toks           = '0;
    n              = '0;
    brk            = 1'b0;

    if (in_end_of_source) begin
      brk = 1'b1;
    end else begin
      unique case (mode_r)
        M_IDENT: begin
          if (is_word(c)) run_len_nxt = sat_inc(run_len_r);
          else brk = 1'b1;
        end
        M_INT, M_FRAC: begin
          if (is_digit(c)) begin
            run_len_nxt = sat_inc(run_len_r);
          end else if ((c == CH_DOT) && (mode_r == M_INT)) begin
            run_len_nxt = sat_inc(run_len_r);
            mode_nxt    = M_FRAC;
          end else if (is_e) begin
            mant_len_nxt = run_len_r;
            mark_nxt     = offset_r;
            run_len_nxt  = sat_inc(run_len_r);
            mode_nxt     = M_EXP_E;
          end else begin
            brk = 1'b1;
          end
        end
        M_DOT: begin
          if (is_digit(c)) begin
            run_len_nxt = sat_inc(run_len_r);
            mode_nxt    = M_FRAC;
          end else begin
            brk = 1'b1;
          end
        end
        M_EXP_E: begin
          if (is_digit(c)) begin
            run_len_nxt = sat_inc(run_len_r);
            mode_nxt    = M_EXP_DIG;
          end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
            sign_minus_nxt = (c == CH_MINUS);
            run_len_nxt    = sat_inc(run_len_r);
            mode_nxt       = M_EXP_SIGN;
          end else if (is_word(c)) begin
            // The bare 'e' turns into the head of an identifier.
            toks[0]     = mk_tok(etok_pkg::K_NUMBER, begin_r, mant_len_r);
            n           = etok_pkg::TOK_CNT_BITS'(1);
            begin_nxt   = mark_r;
            run_len_nxt = LEN_TWO;
            mode_nxt    = M_IDENT;
          end else begin
            brk = 1'b1;
          end
        end
        M_EXP_SIGN, M_EXP_DIG: begin
          if (is_digit(c)) begin
            run_len_nxt = sat_inc(run_len_r);
            mode_nxt    = M_EXP_DIG;
          end else begin
            brk = 1'b1;
          end
        end
        M_IDLE: brk = 1'b1;
      endcase
    end

    if (brk) begin
      // Close whatever token is pending.
      unique case (mode_r)
        M_IDENT: begin
          toks[n[etok_pkg::TOK_IDX_BITS-1:0]] = mk_tok(etok_pkg::K_IDENT, begin_r, run_len_r);
          n = n + 1'b1;
        end
        M_INT, M_FRAC, M_EXP_DIG: begin
          toks[n[etok_pkg::TOK_IDX_BITS-1:0]] = mk_tok(etok_pkg::K_NUMBER, begin_r, run_len_r);
          n = n + 1'b1;
        end
        M_DOT: begin
          toks[n[etok_pkg::TOK_IDX_BITS-1:0]] = mk_tok(etok_pkg::K_ERROR, begin_r, LEN_ONE);
          n = n + 1'b1;
        end
        M_EXP_E, M_EXP_SIGN: begin
          toks[n[etok_pkg::TOK_IDX_BITS-1:0]] = mk_tok(etok_pkg::K_NUMBER, begin_r, mant_len_r);
          n = n + 1'b1;
          toks[n[etok_pkg::TOK_IDX_BITS-1:0]] = mk_tok(etok_pkg::K_IDENT, mark_r, LEN_ONE);
          n = n + 1'b1;
          if (mode_r == M_EXP_SIGN) begin
            toks[n[etok_pkg::TOK_IDX_BITS-1:0]] =
              mk_tok(sign_minus_r ? etok_pkg::K_MINUS : etok_pkg::K_PLUS,
                     mark_r + OFF_ONE, LEN_ONE);
            n = n + 1'b1;
          end
        end
        M_IDLE: ;
      endcase
      mode_nxt = M_IDLE;

      if (in_end_of_source) begin
        toks[n[etok_pkg::TOK_IDX_BITS-1:0]] = mk_tok(etok_pkg::K_EOF, offset_r, '0);
        n = n + 1'b1;
      end else if (!is_space(c)) begin
        begin_nxt   = offset_r;
        run_len_nxt = LEN_ONE;
        if (is_digit(c)) begin
          mode_nxt = M_INT;
        end else if (c == CH_DOT) begin
          mode_nxt = M_DOT;
        end else if (is_alpha(c) || (c == CH_UNDER)) begin
          mode_nxt = M_IDENT;
        end else begin
          toks[n[etok_pkg::TOK_IDX_BITS-1:0]] = mk_tok(op_kind(c), offset_r, LEN_ONE);
          n = n + 1'b1;
        end
      end
    end
  end

  assign push          = acc && (n != '0);
  assign push_data.cnt = n;
  assign push_data.tok = toks;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= M_IDLE;
      offset_r     <= '0;
      begin_r      <= '0;
      mark_r       <= '0;
      sign_minus_r <= 1'b0;
      run_len_r    <= '0;
      mant_len_r   <= '0;
    end else if (acc) begin
      mode_r       <= mode_nxt;
      offset_r     <= offset_nxt;
      begin_r      <= begin_nxt;
      mark_r       <= mark_nxt;
      sign_minus_r <= sign_minus_nxt;
      run_len_r    <= run_len_nxt;
      mant_len_r   <= mant_len_nxt;
    end
  end

endmodule

/* design/etok_queue.sv */
module etok_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  etok_pkg::bundle_t  push_data,
  input  logic               pop,
  output etok_pkg::bundle_t  pop_data,
  output etok_pkg::q_stat_t  stat
);

  etok_pkg::bundle_t mem_r [etok_pkg::Q_DEPTH];

  logic [etok_pkg::Q_PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [etok_pkg::Q_CNT_BITS-1:0] count_r, count_nxt;
  logic                            do_push, do_pop;

  assign stat.valid = (count_r != '0);
  assign stat.full  = (count_r == etok_pkg::Q_CNT_BITS'(etok_pkg::Q_DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && stat.valid;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule

/* design/etok_back.sv */
module etok_back (
  input  logic               clk,
  input  logic               rst_n,
  input  etok_pkg::q_stat_t  q_stat,
  input  etok_pkg::bundle_t  q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_token_kind,
  output logic [15:0]        out_token_start,
  output logic [15:0]        out_token_length,
  output logic               out_last_of_run
);

  etok_pkg::bundle_t                 cur_r;
  logic                              cur_valid_r;
  logic [etok_pkg::TOK_IDX_BITS-1:0] idx_r;
  etok_pkg::tok_t                    tok;
  logic                              fire, last, take;

  assign tok  = cur_r.tok[idx_r];
  assign last = (etok_pkg::TOK_CNT_BITS'(idx_r) + 1'b1) == cur_r.cnt;
  assign fire = cur_valid_r && out_ready;
  // Load the next bundle when empty or when the final token leaves.
  assign take  = !cur_valid_r || (fire && last);
  assign q_pop = take && q_stat.valid;

  assign out_valid        = cur_valid_r;
  assign out_token_kind   = tok.kind;
  assign out_token_start  = tok.start;
  assign out_token_length = tok.len;
  assign out_last_of_run  = last;

  always_ff @(posedge clk) begin
    if (take) cur_r <= q_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (take) begin
      cur_valid_r <= q_stat.valid;
      idx_r       <= '0;
    end else if (fire) begin
      idx_r <= idx_r + 1'b1;
    end
  end

endmodule

/* design/expression_tokenizer_core.sv */
// Path: the tokens of an accepted byte are written into the queue, then loaded into the output stage register.
// Throughput: one byte per cycle while the queue is not full; the output stage hands out one token
// per transfer, so an item that gives k tokens holds it for k transfers; a four-bundle queue absorbs bursts.
// Reset (synchronous, active low) returns the scanner to idle at offset zero and empties
// the queue and the output stage.
`include "expression_tokenizer_core_macros.svh"

module expression_tokenizer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_byte,
  input  logic        in_end_of_source,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_token_kind,
  output logic [15:0] out_token_start,
  output logic [15:0] out_token_length,
  output logic        out_last_of_run
);

  // The front end scans one byte per transfer and turns it into a bundle of
  // zero to four tokens. Bundles wait in a short queue so the scanner keeps
  // taking bytes while the back end is still handing out earlier tokens.
  etok_pkg::q_stat_t q_stat;
  etok_pkg::bundle_t push_data;
  etok_pkg::bundle_t pop_data;
  logic              push;
  logic              pop;

  etok_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_char_byte     (in_char_byte),
    .in_end_of_source (in_end_of_source),
    .in_ready         (in_ready),
    .q_stat           (q_stat),
    .push             (push),
    .push_data        (push_data)
  );

  // The queue holds whole bundles, so the tokens of one byte stay together
  // and in order.
  etok_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  // The back end hands out one token per transfer and flags the final token
  // of each bundle.
  etok_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .q_data           (pop_data),
    .q_pop            (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_last_of_run  (out_last_of_run)
  );

  // An end-of-source token is always the final token of its input item.
  `ETOK_ASSERT(a_eof_last, out_valid && (out_token_kind == etok_pkg::K_EOF) |-> out_last_of_run, "EOF token not flagged as last")

  // Only the end-of-source token can have zero length.
  `ETOK_ASSERT(a_zero_len_eof, out_valid && (out_token_length == '0) |-> (out_token_kind == etok_pkg::K_EOF), "zero-length token that is not EOF")

  // The scanner never pushes a bundle into a full queue.
  `ETOK_ASSERT(a_no_overflow, push |-> !q_stat.full, "bundle pushed into a full queue")

  // Reset leaves no token on the output.
  `ETOK_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid, "output valid right after reset")

endmodule
